### hw/rtl/assert_macros.svh
// Assertion macros used by button_gesture_classifier for its concurrent checks.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/bgc_pkg.sv
// Types, codes and defaults shared by the button gesture classifier modules.
// No dependencies.
package bgc_pkg;

  localparam int BGC_TIME_BITS       = 32;
  localparam int BGC_ADC_BITS        = 12;
  localparam int BGC_REPEAT_DELAY_MS = 700;
  localparam int BGC_WINDOW_RESET    = 280;

  localparam int PIN_W    = 12;
  localparam int NOW_W    = 32;
  localparam int MS_W     = 16;
  localparam int TALLY_W  = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PRESS = 2'd0,
    REG_WINDOW     = 2'd1,
    REG_ACTIVE_LOW = 2'd2,
    REG_ANALOG_THR = 2'd3
  } bgc_reg_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_CLICK  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_TRIPLE = 3'd3,
    EV_LONG   = 3'd4
  } bgc_event_t;

  typedef struct packed {
    logic [MS_W-1:0]  long_press_ms;
    logic [MS_W-1:0]  window_ms;
    logic             active_low;
    logic [PIN_W-1:0] adc_threshold;
  } bgc_cfg_t;

  typedef struct packed {
    logic strobe;
    logic level;
  } bgc_relevel_t;

  typedef struct packed {
    logic op_cancel;
    logic level;
    logic pressed;
    logic rpt;
  } bgc_flags_t;

endpackage

### hw/rtl/bgc_front.sv
// Front end: turns a raw pin sample into a level and a qualified pressed flag.
// Depends on bgc_pkg.
module bgc_front import bgc_pkg::*; #(
  parameter int ADC_BITS = BGC_ADC_BITS
) (
  input  bgc_cfg_t         cfg,
  input  logic             operation,
  input  logic [PIN_W-1:0] pin_sample,
  input  logic             repeat_enable,
  output bgc_flags_t       flags
);

  localparam int AdcKeep = (ADC_BITS < PIN_W) ? ADC_BITS : PIN_W;
  localparam logic [PIN_W-1:0] AdcMask = PIN_W'((64'd1 << AdcKeep) - 64'd1);

  logic [PIN_W-1:0] sample;
  logic             analog;
  logic             level;

  always_comb begin
    sample = pin_sample & AdcMask;
    analog = (cfg.adc_threshold != '0);
    level  = analog ? (sample < cfg.adc_threshold) : sample[0];
    flags.op_cancel = operation;
    flags.level     = level;
    flags.pressed   = analog ? level : (level ^ cfg.active_low);
    flags.rpt       = repeat_enable;
  end

endmodule

### hw/rtl/bgc_queue.sv
// Two-entry queue that decouples the front end from the gesture back end.
// Depends on bgc_pkg.
module bgc_queue import bgc_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         not_full,
  output logic         not_empty
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign pop_data  = mem[rd_ptr];
  assign not_full  = (count != 2'd2);
  assign not_empty = (count != 2'd0);

endmodule

### hw/rtl/bgc_back.sv
// Back end: edge tracking, click grouping, long press and repeat, with the
// registered result stage. Depends on bgc_pkg.
module bgc_back import bgc_pkg::*; #(
  parameter int TIME_BITS       = BGC_TIME_BITS,
  parameter int REPEAT_DELAY_MS = BGC_REPEAT_DELAY_MS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bgc_cfg_t             cfg,
  input  bgc_relevel_t         relevel,
  input  logic                 item_valid,
  input  bgc_flags_t           item_flags,
  input  logic [TIME_BITS-1:0] item_time,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bgc_event_t           event_code,
  output logic                 pressed_now
);

  localparam logic [TIME_BITS-1:0] RepeatDelay = TIME_BITS'(REPEAT_DELAY_MS);
  localparam logic [TALLY_W-1:0]   TallyMax    = '1;

  logic                 last_level;
  logic                 press_held;
  logic [TIME_BITS-1:0] press_start_time;
  logic [TALLY_W-1:0]   click_tally;
  logic [TIME_BITS-1:0] last_click_stamp;
  logic                 click_waiting;

  logic                 last_level_next;
  logic                 press_held_next;
  logic [TIME_BITS-1:0] press_start_time_next;
  logic [TALLY_W-1:0]   click_tally_next;
  logic [TIME_BITS-1:0] last_click_stamp_next;
  logic                 click_waiting_next;
  bgc_event_t           event_next;

  logic [TIME_BITS-1:0] hold_time;
  logic [TIME_BITS-1:0] quiet_time;
  logic [TIME_BITS-1:0] long_limit;
  logic [TIME_BITS-1:0] window;
  logic                 edge_seen;
  logic                 clicked;
  logic                 long_hit;
  logic [TALLY_W-1:0]   tally_dec;

  assign pop = item_valid && (!out_valid || !out_stall);

  always_comb begin
    hold_time  = item_time - press_start_time;
    quiet_time = item_time - last_click_stamp;
    long_limit = TIME_BITS'(cfg.long_press_ms);
    window     = TIME_BITS'(cfg.window_ms);
    edge_seen  = (item_flags.level != last_level);
    clicked    = 1'b0;
    long_hit   = 1'b0;
    tally_dec  = '0;
    event_next = EV_NONE;

    last_level_next       = last_level;
    press_held_next       = press_held;
    press_start_time_next = press_start_time;
    click_tally_next      = click_tally;
    last_click_stamp_next = last_click_stamp;
    click_waiting_next    = click_waiting;

    if (item_flags.op_cancel) begin
      press_held_next       = 1'b0;
      press_start_time_next = '0;
      click_tally_next      = '0;
      last_click_stamp_next = '0;
      click_waiting_next    = 1'b0;
    end else begin
      if (edge_seen) begin
        last_level_next = item_flags.level;
        if (item_flags.pressed) begin
          press_held_next       = 1'b1;
          press_start_time_next = item_time;
        end else begin
          if (cfg.long_press_ms != '0) begin
            clicked = press_held && (hold_time < long_limit);
          end else begin
            clicked = 1'b1;
          end
          press_held_next       = 1'b0;
          press_start_time_next = '0;
        end
      end
      if (clicked) begin
        if (click_tally != TallyMax) begin
          click_tally_next = click_tally + 1'b1;
        end
        last_click_stamp_next = item_time;
        click_waiting_next    = 1'b1;
      end

      // The hold time is only meaningful when the hold predates this item.
      long_hit = (cfg.long_press_ms != '0) && press_held && !edge_seen &&
                 (hold_time >= long_limit);
      if (long_hit) begin
        if (!click_waiting_next) begin
          event_next = EV_LONG;
        end
        press_held_next       = 1'b0;
        press_start_time_next = '0;
        click_tally_next      = '0;
        last_click_stamp_next = '0;
        click_waiting_next    = 1'b0;
      end

      if (press_held_next && !edge_seen && item_flags.rpt && (hold_time >= RepeatDelay)) begin
        event_next = EV_CLICK;
      end

      if (cfg.window_ms == '0) begin
        if (click_waiting_next && !press_held_next) begin
          event_next = EV_CLICK;
          tally_dec  = (click_tally_next != '0) ? click_tally_next - 1'b1 : '0;
          click_tally_next = tally_dec;
          if (tally_dec == '0) begin
            last_click_stamp_next = '0;
            click_waiting_next    = 1'b0;
          end
        end
      end else if (click_waiting_next && !press_held_next && !clicked &&
                   (quiet_time >= window)) begin
        if (click_tally_next <= TALLY_W'(1)) begin
          event_next = EV_CLICK;
        end else if (click_tally_next == TALLY_W'(2)) begin
          event_next = EV_DOUBLE;
        end else begin
          event_next = EV_TRIPLE;
        end
        click_tally_next      = '0;
        last_click_stamp_next = '0;
        click_waiting_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level       <= 1'b0;
      press_held       <= 1'b0;
      press_start_time <= '0;
      click_tally      <= '0;
      last_click_stamp <= '0;
      click_waiting    <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (pop) begin
        last_level       <= last_level_next;
        press_held       <= press_held_next;
        press_start_time <= press_start_time_next;
        click_tally      <= click_tally_next;
        last_click_stamp <= last_click_stamp_next;
        click_waiting    <= click_waiting_next;
      end else if (relevel.strobe) begin
        last_level <= relevel.level;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      event_code  <= event_next;
      pressed_now <= item_flags.pressed;
    end
  end

endmodule

### hw/rtl/button_gesture_classifier.sv
// A transferred poll passes through a queue entry and then the result register.
// Throughput: one poll per cycle; the two-entry queue and the result register
// let input and output stall independently.
// Reset (rst, synchronous): queue empty, no result pending, gesture state cleared,
// registers back to long press 0, window 280 ms, active high, digital mode.
// Depends on bgc_pkg, bgc_front, bgc_queue, bgc_back and assert_macros.svh.
`include "assert_macros.svh"

module button_gesture_classifier import bgc_pkg::*; #(
  parameter int TIME_BITS       = BGC_TIME_BITS,
  parameter int ADC_BITS        = BGC_ADC_BITS,
  parameter int REPEAT_DELAY_MS = BGC_REPEAT_DELAY_MS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  operation,
  input  logic [PIN_W-1:0]      pin_sample,
  input  logic [NOW_W-1:0]      now_ms,
  input  logic                  repeat_enable,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            event_code,
  output logic                  pressed_now
);

  localparam int FlagsW = $bits(bgc_flags_t);
  localparam int QW     = FlagsW + TIME_BITS;

  bgc_cfg_t              cfg;
  bgc_relevel_t          relevel;
  bgc_flags_t            in_flags;
  bgc_flags_t            q_flags;
  logic [TIME_BITS+NOW_W-1:0] now_wide;
  logic [TIME_BITS-1:0]  in_time;
  logic [QW-1:0]         q_out;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_not_full;
  logic                  q_not_empty;
  bgc_event_t            ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ms    <= '0;
      cfg.window_ms        <= MS_W'(BGC_WINDOW_RESET);
      cfg.active_low       <= 1'b0;
      cfg.adc_threshold    <= '0;
      relevel              <= '0;
    end else begin
      relevel.strobe <= cfg_we &&
                        (bgc_reg_t'(cfg_index) inside {REG_ACTIVE_LOW, REG_ANALOG_THR});
      if (cfg_we) begin
        unique case (bgc_reg_t'(cfg_index))
          REG_LONG_PRESS: cfg.long_press_ms <= cfg_data[MS_W-1:0];
          REG_WINDOW:     cfg.window_ms     <= cfg_data[MS_W-1:0];
          REG_ACTIVE_LOW: begin
            cfg.active_low <= cfg_data[0];
            relevel.level  <= (cfg.adc_threshold == '0) && cfg_data[0];
          end
          REG_ANALOG_THR: begin
            cfg.adc_threshold <= cfg_data[PIN_W-1:0];
            relevel.level     <= (cfg_data[PIN_W-1:0] == '0) && cfg.active_low;
          end
          default: ;
        endcase
      end
    end
  end

  assign now_wide = {{TIME_BITS{1'b0}}, now_ms};
  assign in_time  = now_wide[TIME_BITS-1:0];
  assign in_stall = !q_not_full;
  assign q_push   = in_valid && q_not_full;

  bgc_front #(
    .ADC_BITS(ADC_BITS)
  ) u_front (
    .cfg          (cfg),
    .operation    (operation),
    .pin_sample   (pin_sample),
    .repeat_enable(repeat_enable),
    .flags        (in_flags)
  );

  bgc_queue #(
    .W(QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data({in_flags, in_time}),
    .pop      (q_pop),
    .pop_data (q_out),
    .not_full (q_not_full),
    .not_empty(q_not_empty)
  );

  assign q_flags = bgc_flags_t'(q_out[QW-1:TIME_BITS]);

  bgc_back #(
    .TIME_BITS      (TIME_BITS),
    .REPEAT_DELAY_MS(REPEAT_DELAY_MS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .relevel    (relevel),
    .item_valid (q_not_empty),
    .item_flags (q_flags),
    .item_time  (q_out[TIME_BITS-1:0]),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_code (ev),
    .pressed_now(pressed_now)
  );

  assign event_code = ev;

  `ASSERT_IMPLIES(a_pop_needs_entry, clk, rst, q_pop, q_not_empty)
  `ASSERT_NEXT(a_queue_drains_to_output, clk, rst, (!out_valid && q_not_empty), out_valid)
  `ASSERT_IMPLIES(a_event_in_range, clk, rst, out_valid, (event_code <= EV_LONG))

endmodule

### bench/tb_top.sv
// Self-checking bench for button_gesture_classifier: directed rows, then gesture streams.
// The expected results come from an independent predictor in this file.
// Depends on bgc_pkg and the button_gesture_classifier RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bgc_pkg::*;

  localparam logic OP_POLL   = 1'b0;
  localparam logic OP_CANCEL = 1'b1;

  typedef struct {
    logic             op;
    logic [PIN_W-1:0] sample;
    logic [NOW_W-1:0] now;
    logic             rpt;
  } poll_t;

  typedef struct {
    bgc_event_t ev;
    logic       pressed;
  } gesture_t;

  typedef struct {
    bit                    is_cfg;
    bgc_reg_t              cfg_sel;
    logic [CFG_DATA_W-1:0] cfg_val;
    poll_t                 p;
    gesture_t              want;
  } drill_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  operation = OP_POLL;
  logic [PIN_W-1:0]      pin_sample = '0;
  logic [NOW_W-1:0]      now_ms = '0;
  logic                  repeat_enable = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            event_code;
  logic                  pressed_now;

  // Predictor copy of the registers and the gesture state.
  logic [MS_W-1:0]    long_ms = '0;
  logic [MS_W-1:0]    window_ms = MS_W'(BGC_WINDOW_RESET);
  logic               low_active = 1'b0;
  logic [PIN_W-1:0]   adc_thresh = '0;
  logic               btn_level = 1'b0;
  logic               hold_on = 1'b0;
  logic [NOW_W-1:0]   hold_start = '0;
  logic [TALLY_W-1:0] tally = '0;
  logic [NOW_W-1:0]   click_stamp = '0;
  logic               clicks_open = 1'b0;

  gesture_t   gesture_due[$];
  drill_t     drill[$];
  int         gesture_errors = 0;
  int         snd_pct = 0;
  int         rcv_pct = 0;
  int         hold_left = 0;
  logic [NOW_W-1:0] clock_ms = 32'hFFFF_F000;

  button_gesture_classifier DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .pin_sample(pin_sample), .now_ms(now_ms),
    .repeat_enable(repeat_enable),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_code(event_code), .pressed_now(pressed_now)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic counts_pressed(logic lvl);
    if (adc_thresh != 0) return lvl;
    return low_active ? !lvl : lvl;
  endfunction

  function automatic void drop_gesture();
    hold_on = 1'b0;
    hold_start = '0;
    tally = '0;
    click_stamp = '0;
    clicks_open = 1'b0;
  endfunction

  function automatic gesture_t classify_poll(poll_t p);
    logic             lvl;
    logic [NOW_W-1:0] held_for;
    gesture_t         r;
    lvl = (adc_thresh != 0) ? (p.sample < adc_thresh) : p.sample[0];
    r.pressed = counts_pressed(lvl);
    r.ev = EV_NONE;
    if (p.op == OP_CANCEL) begin
      drop_gesture();
      return r;
    end
    if (lvl != btn_level) begin
      if (counts_pressed(lvl)) begin
        hold_on = 1'b1;
        hold_start = p.now;
      end else begin
        held_for = p.now - hold_start;
        if (long_ms == 0 || (hold_on && held_for < long_ms)) begin
          if (tally != '1) tally++;
          click_stamp = p.now;
          clicks_open = 1'b1;
        end
        hold_on = 1'b0;
        hold_start = '0;
      end
      btn_level = lvl;
    end
    held_for = p.now - hold_start;
    if (long_ms != 0 && hold_on && held_for >= long_ms) begin
      if (!clicks_open) r.ev = EV_LONG;
      drop_gesture();
    end
    if (hold_on && p.rpt && held_for >= BGC_REPEAT_DELAY_MS) r.ev = EV_CLICK;
    held_for = p.now - click_stamp;
    if (window_ms == 0) begin
      if (clicks_open && !hold_on) begin
        r.ev = EV_CLICK;
        if (tally != 0) tally--;
        if (tally == 0) begin
          click_stamp = '0;
          clicks_open = 1'b0;
        end
      end
    end else if (clicks_open && !hold_on && held_for >= window_ms) begin
      if (tally <= 1) r.ev = EV_CLICK;
      else if (tally == 2) r.ev = EV_DOUBLE;
      else r.ev = EV_TRIPLE;
      tally = '0;
      click_stamp = '0;
      clicks_open = 1'b0;
    end
    return r;
  endfunction

  function automatic drill_t poll_row(logic op, logic [PIN_W-1:0] s, logic [NOW_W-1:0] t,
                                      logic rpt, bgc_event_t ev, logic pr);
    drill_t d;
    d.is_cfg = 1'b0;
    d.cfg_sel = REG_LONG_PRESS;
    d.cfg_val = '0;
    d.p = '{op, s, t, rpt};
    d.want = '{ev, pr};
    return d;
  endfunction

  function automatic drill_t cfg_row(bgc_reg_t sel, logic [CFG_DATA_W-1:0] val);
    drill_t d;
    d = poll_row(OP_POLL, '0, '0, 1'b0, EV_NONE, 1'b0);
    d.is_cfg = 1'b1;
    d.cfg_sel = sel;
    d.cfg_val = val;
    return d;
  endfunction

  function automatic logic [PIN_W-1:0] sample_for(bit down);
    logic [PIN_W-1:0] s;
    if (adc_thresh != 0) begin
      if (down) s = PIN_W'($urandom_range(0, adc_thresh - 1));
      else s = PIN_W'($urandom_range(adc_thresh, 4095));
    end else begin
      s = PIN_W'($urandom);
      s[0] = low_active ? !down : down;
    end
    return s;
  endfunction

  function automatic logic [NOW_W-1:0] next_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return $urandom_range(0, 30);
    if (roll < 80) return $urandom_range(0, 400);
    if (roll < 95) return $urandom_range(0, 1500);
    if (roll < 98) return $urandom_range(0, 70000);
    return $urandom;
  endfunction

  function automatic logic [MS_W-1:0] pick_ms();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return MS_W'($urandom_range(1, 400));
      3: return MS_W'($urandom_range(400, 2000));
      default: return MS_W'($urandom);
    endcase
  endfunction

  function automatic logic [PIN_W-1:0] pick_thresh();
    case ($urandom_range(0, 4))
      0, 1: return '0;
      2: return PIN_W'(1);
      3: return PIN_W'(4095);
      default: return PIN_W'($urandom_range(2, 4094));
    endcase
  endfunction

  // Offer one poll and keep it steady until the transfer; valid stays high afterwards.
  task automatic offer_poll(input poll_t p, input bit typed, input gesture_t want);
    gesture_t got;
    if ($urandom_range(0, 99) < snd_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_pct);
    end
    in_valid <= 1'b1;
    operation <= p.op;
    pin_sample <= p.sample;
    now_ms <= p.now;
    repeat_enable <= p.rpt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = classify_poll(p);
    gesture_due.push_back(typed ? want : got);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (gesture_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [3:0] mask, input logic [CFG_DATA_W-1:0] v_long,
                              input logic [CFG_DATA_W-1:0] v_win, v_low, v_thr);
    logic [CFG_DATA_W-1:0] vals [4];
    bgc_reg_t              sel;
    vals = '{v_long, v_win, v_low, v_thr};
    settle();
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        sel = bgc_reg_t'(i);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= vals[i];
        @(posedge clk);
        case (sel)
          REG_LONG_PRESS: long_ms = vals[i];
          REG_WINDOW: window_ms = vals[i];
          REG_ACTIVE_LOW: begin
            low_active = vals[i][0];
            btn_level = (adc_thresh == 0) && low_active;
          end
          REG_ANALOG_THR: begin
            adc_thresh = vals[i][PIN_W-1:0];
            btn_level = (adc_thresh == 0) && low_active;
          end
          default: ;
        endcase
      end
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_gestures(input int count, input int toggle_pct, input bit quick);
    poll_t    p;
    gesture_t none;
    bit       down;
    int       roll;
    none = '{EV_NONE, 1'b0};
    down = 1'b0;
    repeat (count) begin
      roll = quick ? 99 : $urandom_range(0, 99);
      p.rpt = 1'($urandom_range(0, 1));
      p.op = OP_POLL;
      clock_ms = clock_ms + (quick ? NOW_W'($urandom_range(0, 1)) : next_gap());
      p.now = clock_ms;
      if (roll < 3) begin
        p.op = OP_CANCEL;
        p.sample = PIN_W'($urandom);
      end else if (roll < 8) begin
        p.sample = PIN_W'($urandom);
        p.now = $urandom;
      end else begin
        if ($urandom_range(0, 99) < toggle_pct) down = !down;
        p.sample = sample_for(down);
      end
      offer_poll(p, 1'b0, none);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rcv_pct);
      end
    end
  end

  initial begin
    gesture_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (gesture_due.size() == 0) begin
          if (gesture_errors < 10)
            $display("unexpected transfer: event %0d pressed %0b", event_code, pressed_now);
          gesture_errors++;
        end else begin
          want = gesture_due.pop_front();
          if (event_code !== want.ev || pressed_now !== want.pressed) begin
            if (gesture_errors < 10)
              $display("mismatch: event exp %0d got %0d, pressed exp %0b got %0b",
                       want.ev, event_code, want.pressed, pressed_now);
            gesture_errors++;
          end
        end
      end
    end
  end

  initial begin
    drill_t d;
    drill.push_back(poll_row(OP_POLL, 12'h000, 32'd0, 1'b0, EV_NONE, 1'b0));
    drill.push_back(poll_row(OP_POLL, 12'h001, 32'd0, 1'b0, EV_NONE, 1'b1));
    drill.push_back(poll_row(OP_POLL, 12'h001, 32'd100, 1'b1, EV_NONE, 1'b1));
    drill.push_back(poll_row(OP_POLL, 12'h001, 32'd700, 1'b1, EV_CLICK, 1'b1));
    drill.push_back(poll_row(OP_POLL, 12'h000, 32'd710, 1'b0, EV_NONE, 1'b0));
    drill.push_back(poll_row(OP_POLL, 12'h000, 32'd990, 1'b0, EV_CLICK, 1'b0));
    drill.push_back(poll_row(OP_POLL, 12'h001, 32'd1000, 1'b0, EV_NONE, 1'b1));
    drill.push_back(poll_row(OP_POLL, 12'h000, 32'd1010, 1'b0, EV_NONE, 1'b0));
    drill.push_back(poll_row(OP_POLL, 12'h001, 32'd1020, 1'b0, EV_NONE, 1'b1));
    drill.push_back(poll_row(OP_POLL, 12'h000, 32'd1030, 1'b0, EV_NONE, 1'b0));
    drill.push_back(poll_row(OP_POLL, 12'h000, 32'd1309, 1'b0, EV_NONE, 1'b0));
    drill.push_back(poll_row(OP_POLL, 12'h000, 32'd1310, 1'b0, EV_DOUBLE, 1'b0));
    drill.push_back(poll_row(OP_POLL, 12'hFFF, 32'd1400, 1'b0, EV_NONE, 1'b1));
    drill.push_back(poll_row(OP_CANCEL, 12'hFFF, 32'hFFFF_FFFF, 1'b1, EV_NONE, 1'b1));
    // The cancel leaves the level alone, so this release still counts a click.
    drill.push_back(poll_row(OP_POLL, 12'hFFE, 32'd1420, 1'b0, EV_NONE, 1'b0));
    drill.push_back(poll_row(OP_POLL, 12'h000, 32'd1700, 1'b0, EV_CLICK, 1'b0));
    drill.push_back(poll_row(OP_POLL, 12'h001, 32'd2000, 1'b0, EV_NONE, 1'b1));
    drill.push_back(poll_row(OP_POLL, 12'h000, 32'd2010, 1'b0, EV_NONE, 1'b0));
    drill.push_back(poll_row(OP_POLL, 12'h001, 32'd2020, 1'b0, EV_NONE, 1'b1));
    drill.push_back(poll_row(OP_POLL, 12'h000, 32'd2030, 1'b0, EV_NONE, 1'b0));
    drill.push_back(poll_row(OP_POLL, 12'h001, 32'd2040, 1'b0, EV_NONE, 1'b1));
    drill.push_back(poll_row(OP_POLL, 12'h000, 32'd2050, 1'b0, EV_NONE, 1'b0));
    drill.push_back(poll_row(OP_POLL, 12'h000, 32'd2330, 1'b0, EV_TRIPLE, 1'b0));
    drill.push_back(cfg_row(REG_LONG_PRESS, 16'd100));
    drill.push_back(poll_row(OP_POLL, 12'h001, 32'd5000, 1'b0, EV_NONE, 1'b1));
    drill.push_back(poll_row(OP_POLL, 12'h001, 32'd5100, 1'b0, EV_LONG, 1'b1));
    drill.push_back(poll_row(OP_POLL, 12'h000, 32'd5110, 1'b0, EV_NONE, 1'b0));
    drill.push_back(cfg_row(REG_WINDOW, 16'd0));
    drill.push_back(poll_row(OP_POLL, 12'h001, 32'd6000, 1'b0, EV_NONE, 1'b1));
    drill.push_back(poll_row(OP_POLL, 12'h000, 32'd6010, 1'b0, EV_CLICK, 1'b0));
    drill.push_back(cfg_row(REG_ACTIVE_LOW, 16'd1));
    drill.push_back(poll_row(OP_POLL, 12'h000, 32'd6100, 1'b0, EV_NONE, 1'b1));
    drill.push_back(cfg_row(REG_ANALOG_THR, 16'd4095));
    // The hold started by the active-low press is still running and reaches the limit here.
    drill.push_back(poll_row(OP_POLL, 12'hFFF, 32'd6200, 1'b0, EV_LONG, 1'b0));
    drill.push_back(poll_row(OP_POLL, 12'hFFE, 32'd6210, 1'b0, EV_NONE, 1'b1));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    settle();

    foreach (drill[i]) begin
      d = drill[i];
      if (d.is_cfg)
        program_regs(4'b0001 << d.cfg_sel, d.cfg_val, d.cfg_val, d.cfg_val, d.cfg_val);
      else
        offer_poll(d.p, 1'b1, d.want);
    end

    // Fast clicks inside a wide window drive the tally into saturation.
    program_regs(4'hF, 16'd0, 16'hFFFF, 16'd0, 16'd0);
    run_gestures(520, 100, 1'b1);

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: program_regs(4'hF, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        1: program_regs(4'hF, 16'd0, 16'hFFFF, 16'd1, 16'd0);
        2: program_regs(4'hF, pick_ms(), pick_ms(), CFG_DATA_W'($urandom_range(0, 1)),
                        16'd4095);
        3: program_regs(4'hF, pick_ms(), pick_ms(), CFG_DATA_W'($urandom_range(0, 1)),
                        16'd1);
        default: program_regs(4'hF, pick_ms(), pick_ms(),
                              CFG_DATA_W'($urandom_range(0, 1)), pick_thresh());
      endcase
      case (ph % 4)
        0: begin snd_pct = 0; rcv_pct = 0; end
        1: begin snd_pct = 47; rcv_pct = 0; end
        2: begin snd_pct = 0; rcv_pct = 47; end
        default: begin snd_pct = 11; rcv_pct = 11; end
      endcase
      if (ph == 4) hold_left = 80;
      case ($urandom_range(0, 2))
        0: run_gestures(6, 10, 1'b0);
        1: run_gestures(6, 35, 1'b0);
        default: run_gestures(6, 70, 1'b0);
      endcase
    end

    settle();
    repeat (6) @(posedge clk);
    if (gesture_errors == 0 && gesture_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
